// File: rtl/fpba_pkg.sv
package fpba_pkg;

    // Fixed field widths of the ports.
    localparam int ENTRY_W     = 4;
    localparam int REQ_W       = 16;
    localparam int LEFT_W      = 16;
    localparam int POLICY_W    = 2;
    localparam int COUNT_REG_W = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'b1;

    localparam logic [COUNT_REG_W-1:0] BLOCKS_IN_USE_RST = 5'd16;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic clear;
        logic sample;
    } t_sel_ctrl;

endpackage

// File: rtl/fpba_select.sv
module fpba_select #(
    parameter int IDX_W     = 4,
    parameter int SIZE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fpba_pkg::t_sel_ctrl          i_ctrl,
    input  logic [fpba_pkg::POLICY_W-1:0] i_policy,
    input  logic [fpba_pkg::REQ_W-1:0]   i_req,
    input  logic [SIZE_BITS-1:0]         i_rd_size,
    input  logic [IDX_W-1:0]             i_rd_idx,
    output logic                         o_found,
    output logic [IDX_W-1:0]             o_best_idx,
    output logic [SIZE_BITS-1:0]         o_best_size
);
    import fpba_pkg::*;

    localparam int CW = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

    logic                 r_found;
    logic                 n_found;
    logic [IDX_W-1:0]     r_best_idx;
    logic [SIZE_BITS-1:0] r_best_size;
    logic [CW-1:0]        rd_ext;
    logic [CW-1:0]        req_ext;
    logic                 fits;
    logic                 take;

    assign rd_ext  = CW'(i_rd_size);
    assign req_ext = CW'(i_req);
    assign fits    = (rd_ext >= req_ext);

    // First fit (and the unused code) keeps the first hit; the other two
    // replace only on a strictly better size, so ties stay at the lower index.
    always_comb begin
        take = 1'b0;
        if (fits) begin
            if (!r_found) begin
                take = 1'b1;
            end else begin
                case (i_policy)
                    FIT_BEST:  take = (i_rd_size < r_best_size);
                    FIT_WORST: take = (i_rd_size > r_best_size);
                    default:   take = 1'b0;
                endcase
            end
        end
    end

    always_comb begin
        n_found = r_found;
        if (i_ctrl.clear) begin
            n_found = 1'b0;
        end else if (i_ctrl.sample && take) begin
            n_found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctrl.clear && i_ctrl.sample && take) begin
            r_best_idx  <= i_rd_idx;
            r_best_size <= i_rd_size;
        end
    end

    assign o_found     = r_found;
    assign o_best_idx  = r_best_idx;
    assign o_best_size = r_best_size;

    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !$past(i_ctrl.clear) && $stable(i_req))
            |-> (CW'(r_best_size) >= CW'(i_req)))
        else $error("held best entry does not fit the request");

    a_clear_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |=> !r_found)
        else $error("found flag survived a clear");

    a_found_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_found) |-> $past(i_ctrl.sample && fits))
        else $error("found flag rose without a fitting sample");

endmodule

// File: rtl/fit_policy_block_allocator_top.sv
// Load: no result; the next item may follow at once.
// Allocate: with N = min(blocks_in_use, NUM_BLOCKS), one table read per searched entry,
// then a drain state for the registered read and an update state: busy is high through
// all of them, the result strobe is registered after the update, and a new allocate is
// taken only once busy is low again. N = 0 skips the scan and drain and goes to the update.
// The receiver cannot stall; reset is synchronous, active low; the size table is not cleared.
module fit_policy_block_allocator_top #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_action,
    input  logic [fpba_pkg::ENTRY_W-1:0]    i_entry_index,
    input  logic [fpba_pkg::REQ_W-1:0]      i_size_value,
    input  logic                            i_cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fpba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_result_valid,
    output logic                            o_granted,
    output logic [fpba_pkg::ENTRY_W-1:0]    o_chosen_block,
    output logic [fpba_pkg::LEFT_W-1:0]     o_left_over
);
    import fpba_pkg::*;

    localparam int AW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int CW    = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

    t_state                 r_state;
    t_state                 n_state;
    logic [POLICY_W-1:0]    r_fit_policy;
    logic [COUNT_REG_W-1:0] r_blocks_in_use;
    logic [CNT_W-1:0]       r_limit;
    logic [CNT_W-1:0]       limit_now;
    logic [AW-1:0]          r_addr;
    logic [REQ_W-1:0]       r_req;
    logic                   r_rd_vld;
    logic                   n_rd_vld;
    logic [AW-1:0]          r_rd_idx;
    logic [SIZE_BITS-1:0]   r_rd_data;
    logic [SIZE_BITS-1:0]   mem [NUM_BLOCKS];

    logic                   accept;
    logic                   alloc_go;
    logic                   load_go;
    logic                   last_addr;
    t_sel_ctrl              sel_ctrl;
    logic                   found;
    logic [AW-1:0]          best_idx;
    logic [SIZE_BITS-1:0]   best_size;
    logic [CW-1:0]          diff;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [SIZE_BITS-1:0]   mem_wdata;

    logic                   r_out_vld;
    logic                   r_out_granted;
    logic [ENTRY_W-1:0]     r_out_block;
    logic [LEFT_W-1:0]      r_out_left;

    assign accept    = start && !busy;
    assign alloc_go  = accept && (i_action == ACT_ALLOC);
    assign load_go   = accept && (i_action == ACT_LOAD)
                       && (32'(i_entry_index) < 32'(NUM_BLOCKS));
    assign last_addr = (32'(r_addr) == (32'(r_limit) - 32'd1));
    assign diff      = CW'(best_size) - CW'(r_req);

    always_comb begin
        if (32'(r_blocks_in_use) > 32'(NUM_BLOCKS)) begin
            limit_now = CNT_W'(NUM_BLOCKS);
        end else begin
            limit_now = CNT_W'(r_blocks_in_use);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (alloc_go) begin
                    n_state = (limit_now == '0) ? ST_UPDATE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_addr) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH:  n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        busy           = 1'b1;
        n_rd_vld       = 1'b0;
        sel_ctrl.clear = 1'b0;
        sel_ctrl.sample = r_rd_vld;
        mem_we         = 1'b0;
        mem_waddr      = AW'(i_entry_index);
        mem_wdata      = SIZE_BITS'(i_size_value);
        case (r_state)
            ST_IDLE: begin
                busy           = 1'b0;
                sel_ctrl.clear = alloc_go;
                mem_we         = load_go;
            end
            ST_SCAN: begin
                n_rd_vld = 1'b1;
            end
            ST_FLUSH: begin
                n_rd_vld = 1'b0;
            end
            ST_UPDATE: begin
                mem_we    = found;
                mem_waddr = best_idx;
                mem_wdata = SIZE_BITS'(diff);
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_fit_policy    <= FIT_FIRST;
            r_blocks_in_use <= BLOCKS_IN_USE_RST;
            r_rd_vld        <= 1'b0;
            r_out_vld       <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= (r_state == ST_UPDATE);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FIT_POLICY:    r_fit_policy    <= i_cfg_data[POLICY_W-1:0];
                    REG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg_data[COUNT_REG_W-1:0];
                    default:           r_fit_policy    <= r_fit_policy;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (alloc_go) begin
            r_req   <= i_size_value;
            r_limit <= limit_now;
            r_addr  <= '0;
        end else if (r_state == ST_SCAN && !last_addr) begin
            r_addr <= r_addr + AW'(1);
        end
        r_rd_idx <= r_addr;
        if (r_state == ST_UPDATE) begin
            r_out_granted <= found;
            r_out_block   <= found ? ENTRY_W'(best_idx) : '0;
            r_out_left    <= found ? LEFT_W'(diff) : '0;
        end
    end

    // Size table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[r_addr];
    end

    fpba_select #(
        .IDX_W     (AW),
        .SIZE_BITS (SIZE_BITS)
    ) u_select (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (sel_ctrl),
        .i_policy    (r_fit_policy),
        .i_req       (r_req),
        .i_rd_size   (r_rd_data),
        .i_rd_idx    (r_rd_idx),
        .o_found     (found),
        .o_best_idx  (best_idx),
        .o_best_size (best_size)
    );

    assign o_result_valid = r_out_vld;
    assign o_granted      = r_out_granted;
    assign o_chosen_block = r_out_block;
    assign o_left_over    = r_out_left;

    a_result_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == ST_UPDATE))
        else $error("result strobe without an update cycle");

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_granted) |-> (o_chosen_block == '0 && o_left_over == '0))
        else $error("refused request carries a nonzero block or size");

    a_alloc_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc_go |=> busy)
        else $error("allocate transfer did not raise busy");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (32'(r_addr) < 32'(r_limit)))
        else $error("scan address past the search limit");

endmodule
